[src/nsr_pkg.sv]
package nsr_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_STATES_DEF    = 16;
  localparam int MAX_RELATIONS_DEF = 64;

  localparam int STATE_W      = 4;
  localparam int SYMBOL_W     = 8;
  localparam int NUM_STATES_W = 5;

  localparam logic [NUM_STATES_W-1:0] NUM_STATES_RST = 5'd5;
  localparam logic [SYMBOL_W-1:0]     SYMBOL_MASK    = 8'hff;

  // Register index (byte address bit 2 of the config port)
  localparam logic REG_NUM_STATES = 1'b0;

  // Opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_FEED  = 2'd2;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [STATE_W-1:0]  from_state;
    logic [STATE_W-1:0]  to_state;
    logic [SYMBOL_W-1:0] symbol;
    logic                last_symbol;
  } in_t;

  typedef struct packed {
    logic accepted;
    logic store_overflow;
  } out_t;

  typedef struct packed {
    logic [STATE_W-1:0]  from_state;
    logic [STATE_W-1:0]  to_state;
    logic [SYMBOL_W-1:0] symbol;
  } rel_entry_t;

endpackage

[src/nsr_rel_mem.sv]
module nsr_rel_mem #(
  parameter int DEPTH = nsr_pkg::MAX_RELATIONS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  nsr_pkg::rel_entry_t      wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output nsr_pkg::rel_entry_t      rd_data
);

  nsr_pkg::rel_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, one address per cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[src/nfa_string_recognizer.sv]
// Clear and add-relation items complete from idle; an add into a full store reports store_overflow via ST_WAIT.
// Feed-symbol items scan every stored relation, one relation memory read per cycle
// (registered read port), then commit the new active set in ST_FINISH.
// A last symbol then moves the verdict through ST_WAIT into the output register.
// Throughput: one item at a time; in_ready is high only while the sequencer idles.
// Reset (rst_n low, synchronous): store empty, active set {0}, num_states = 5, no output.
module nfa_string_recognizer #(
  parameter int MAX_STATES    = nsr_pkg::MAX_STATES_DEF,
  parameter int MAX_RELATIONS = nsr_pkg::MAX_RELATIONS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,

  input  logic          in_valid,
  output logic          in_ready,
  input  nsr_pkg::in_t  in_data,

  output logic          out_valid,
  input  logic          out_ready,
  output nsr_pkg::out_t out_data,

  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  localparam int SW = $clog2(MAX_STATES);        // active-set index width
  localparam int EW = $clog2(MAX_STATES + 1);    // effective state count width
  localparam int AW = $clog2(MAX_RELATIONS);     // relation memory address width
  localparam int CW = $clog2(MAX_RELATIONS + 1); // relation count width

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,    // stream relations out of memory, OR matching targets in
    ST_FINISH,  // mask and commit the new active set
    ST_WAIT     // hand the result to the output register
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CW-1:0]                  count_r, count_nxt;    // relations stored
  logic [CW-1:0]                  rd_idx_r, rd_idx_nxt;  // next relation to read
  logic                           rd_vld_r, rd_vld_nxt;  // read data valid this cycle
  logic [MAX_STATES-1:0]          active_r, active_nxt;
  logic [MAX_STATES-1:0]          next_r, next_nxt;      // set being built by the scan
  logic                           started_r, started_nxt;
  logic [nsr_pkg::SYMBOL_W-1:0]   sym_r, sym_nxt;
  logic                           last_r, last_nxt;
  logic [nsr_pkg::NUM_STATES_W-1:0] num_states_r, num_states_nxt;
  nsr_pkg::out_t                  res_r, res_nxt;
  logic                           out_valid_r, out_valid_nxt;
  nsr_pkg::out_t                  out_data_r, out_data_nxt;

  // Relation memory ports
  logic                           mem_we;
  nsr_pkg::rel_entry_t            mem_wdata;
  nsr_pkg::rel_entry_t            mem_rdata;

  // Scan datapath
  logic                           from_hit;
  logic [MAX_STATES-1:0]          hit_vec;
  logic [EW-1:0]                  eff_n;
  logic [MAX_STATES-1:0]          state_mask;
  logic [MAX_STATES-1:0]          masked_set;
  logic                           accept_bit;

  logic                           in_xfer;
  logic                           cfg_wr;
  logic                           out_free;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_free   = !out_valid_r || out_ready;

  // APB: cfg_pready is tied high, one register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == nsr_pkg::REG_NUM_STATES) ?
                      {{(32 - nsr_pkg::NUM_STATES_W){1'b0}}, num_states_r} : 32'd0;

  assign mem_we    = in_xfer && (in_data.opcode == nsr_pkg::OP_ADD) &&
                     (count_r < CW'(MAX_RELATIONS));
  assign mem_wdata = '{from_state: in_data.from_state,
                       to_state:   in_data.to_state,
                       symbol:     in_data.symbol};

  nsr_rel_mem #(
    .DEPTH (MAX_RELATIONS)
  ) u_rel_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (mem_wdata),
    .rd_addr (rd_idx_r[AW-1:0]),
    .rd_data (mem_rdata)
  );

  // Relation match: label equals the symbol and the source state is active.
  // Source or target numbers past the active-set width never match.
  always_comb begin
    from_hit = 1'b0;
    if (32'(mem_rdata.from_state) < MAX_STATES) begin
      from_hit = active_r[SW'(mem_rdata.from_state)];
    end
    hit_vec = '0;
    if (rd_vld_r && from_hit &&
        ((mem_rdata.symbol & nsr_pkg::SYMBOL_MASK) == sym_r) &&
        (32'(mem_rdata.to_state) < MAX_STATES)) begin
      hit_vec[SW'(mem_rdata.to_state)] = 1'b1;
    end
  end

  // Effective state count: 0 acts as 1, above MAX_STATES clamps
  always_comb begin
    if (num_states_r == '0) begin
      eff_n = EW'(1);
    end else if (32'(num_states_r) > MAX_STATES) begin
      eff_n = EW'(MAX_STATES);
    end else begin
      eff_n = EW'(num_states_r);
    end
    for (int i = 0; i < MAX_STATES; i++) begin
      state_mask[i] = (i < 32'(eff_n));
    end
    masked_set = next_r & state_mask;
    accept_bit = 1'b0;
    for (int i = 0; i < MAX_STATES; i++) begin
      if (i == 32'(eff_n) - 1) begin
        accept_bit = masked_set[i];
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    rd_vld_nxt     = 1'b0;
    active_nxt     = active_r;
    next_nxt       = next_r;
    started_nxt    = started_r;
    sym_nxt        = sym_r;
    last_nxt       = last_r;
    num_states_nxt = num_states_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    if (cfg_wr && (cfg_paddr[2] == nsr_pkg::REG_NUM_STATES)) begin
      num_states_nxt = cfg_pwdata[nsr_pkg::NUM_STATES_W-1:0];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_data.opcode)
            nsr_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            nsr_pkg::OP_ADD: begin
              if (count_r < CW'(MAX_RELATIONS)) begin
                count_nxt = count_r + CW'(1);
              end else begin
                res_nxt   = '{accepted: 1'b0, store_overflow: 1'b1};
                state_nxt = ST_WAIT;
              end
            end
            nsr_pkg::OP_FEED: begin
              // A new string starts from {state 0}
              if (!started_r) begin
                active_nxt = MAX_STATES'(1);
              end
              started_nxt = 1'b1;
              sym_nxt     = in_data.symbol & nsr_pkg::SYMBOL_MASK;
              last_nxt    = in_data.last_symbol;
              next_nxt    = '0;
              rd_idx_nxt  = '0;
              state_nxt   = ST_SCAN;
            end
            default: begin
              // unused opcode: ignored
            end
          endcase
        end
      end
      ST_SCAN: begin
        next_nxt = next_r | hit_vec;
        if (rd_idx_r < count_r) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
          rd_vld_nxt = 1'b1;
        end else begin
          // data in flight this cycle (if any) is the last relation
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        active_nxt = masked_set;
        if (last_r) begin
          res_nxt     = '{accepted: accept_bit, store_overflow: 1'b0};
          started_nxt = 1'b0;
          state_nxt   = ST_WAIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      rd_idx_r     <= '0;
      rd_vld_r     <= 1'b0;
      active_r     <= MAX_STATES'(1);
      started_r    <= 1'b0;
      num_states_r <= nsr_pkg::NUM_STATES_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rd_idx_r     <= rd_idx_nxt;
      rd_vld_r     <= rd_vld_nxt;
      active_r     <= active_nxt;
      started_r    <= started_nxt;
      num_states_r <= num_states_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    next_r     <= next_nxt;
    sym_r      <= sym_nxt;
    last_r     <= last_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
